// ----- rtl/bctt_pkg.sv -----
// shared types and constants for the block cache tag table
// no dependencies; imported by bctt_cell and block_cache_tag_table_lru_unit
`timescale 1ns / 1ps
`default_nettype none

package bctt_pkg;

  localparam int DEV_W   = 8;
  localparam int BLK_W   = 32;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 8;
  localparam int SLOT_W  = 5;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;
  // index width for the largest table size (256 entries)
  localparam int IDX_W   = 8;

  localparam logic [MODE_W-1:0] MODE_GET     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PIN     = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_LIMIT = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

  // search token passed from cell to cell
  typedef struct packed {
    logic               active;
    logic               hit;
    logic               vfound;
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   vidx;
    logic [STAMP_W-1:0] best;
  } tok_t;

  // request broadcast to every cell while a token travels
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DEV_W-1:0]  device;
    logic [BLK_W-1:0]  block_number;
    logic [SLOT_W-1:0] slot;
  } req_t;

  // retag of the chosen victim at the end of a get miss
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [STAMP_W-1:0] stamp;
  } wr_t;

endpackage

`default_nettype wire

// ----- rtl/bctt_cell.sv -----
// one table entry: tag, count, stamp and assigned flag, plus one token stage
// depends on bctt_pkg
`timescale 1ns / 1ps
`default_nettype none

module bctt_cell import bctt_pkg::*; #(
  parameter int INDEX = 0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t req,
  input  wire wr_t  wr,
  input  wire tok_t tin,
  output tok_t      tout
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DEV_W-1:0]   device;
  logic [BLK_W-1:0]   block;
  logic [STAMP_W-1:0] stamp;
  logic [CNT_W-1:0]   count;
  logic               assigned;

  logic [CNT_W-1:0]   count_next;
  tok_t               tok_next;
  logic [STAMP_W-1:0] stamp_eff;
  logic               slot_sel;
  logic               wr_sel;

  assign stamp_eff = assigned ? stamp : '0;
  assign slot_sel  = (IDX_W'(req.slot) == MY_IDX);
  assign wr_sel    = wr.en && (wr.idx == MY_IDX);

  always_comb begin
    tok_next   = tin;
    count_next = count;
    if (tin.active) begin
      case (req.mode)
        MODE_GET: begin
          if (assigned && !tin.hit && device == req.device && block == req.block_number) begin
            tok_next.hit     = 1'b1;
            tok_next.hit_idx = MY_IDX;
            if (count == COUNT_MAX) begin
              tok_next.status = STATUS_LIMIT;
            end else begin
              count_next = count + 1'b1;
            end
          end
          // victim: lowest stamp among unreferenced entries, first one wins ties
          if (count == '0 && (!tin.vfound || stamp_eff < tin.best)) begin
            tok_next.vfound = 1'b1;
            tok_next.vidx   = MY_IDX;
            tok_next.best   = stamp_eff;
          end
        end
        MODE_RELEASE: begin
          if (slot_sel) begin
            if (count == '0) begin
              tok_next.status = STATUS_LIMIT;
            end else begin
              count_next = count - 1'b1;
            end
          end
        end
        MODE_PIN: begin
          if (slot_sel) begin
            if (count == COUNT_MAX) begin
              tok_next.status = STATUS_LIMIT;
            end else begin
              count_next = count + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout     <= '0;
      count    <= '0;
      assigned <= 1'b0;
    end else begin
      tout <= tok_next;
      if (wr_sel) begin
        count    <= CNT_W'(1);
        assigned <= 1'b1;
      end else begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      device <= req.device;
      block  <= req.block_number;
      stamp  <= wr.stamp;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/block_cache_tag_table_lru_unit.sv -----
// block cache tag table with reference counts and oldest-allocation replacement
// depends on bctt_pkg and bctt_cell
//
// usage: requests arrive on the in_valid/in_ready channel (mode, device,
// block_number, slot, now); one result per request leaves on the
// out_valid/out_ready channel (entry_index, hit, needs_fill, status).
// each entry lives in its own cell; a search token walks the row of cells,
// one cell per cycle, matching tags, updating counts and tracking the
// oldest unreferenced entry. a get miss retags the chosen entry in the
// cycle the token leaves the last cell.
// the request and a start flag are registered, the token passes every
// cell stage, the decision goes to a result register, then to the output
// register. in_ready is high only while no request is in flight.
// the result sits in an output register, so a new request is taken while
// the previous result waits; if the receiver stalls, a finished scan holds
// its result until the output register frees up.
// reset clears all counts and assigned flags and empties the channels.
`timescale 1ns / 1ps
`default_nettype none

module block_cache_tag_table_lru_unit import bctt_pkg::*; #(
  parameter int ENTRIES = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [DEV_W-1:0]  device,
  input  wire logic [BLK_W-1:0]  block_number,
  input  wire logic [SLOT_W-1:0] slot,
  input  wire logic [STAMP_W-1:0] now,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [SLOT_W-1:0]      entry_index,
  output logic                   hit,
  output logic                   needs_fill,
  output logic [STAT_W-1:0]      status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]         state;
  logic               start;
  req_t               req;
  logic [STAMP_W-1:0] req_now;
  wr_t                wr;
  tok_t               tok [ENTRIES+1];
  tok_t               last;

  logic [SLOT_W-1:0]  res_idx;
  logic               res_hit;
  logic               res_fill;
  logic [STAT_W-1:0]  res_status;

  logic [SLOT_W-1:0]  dec_idx;
  logic               dec_hit;
  logic               dec_fill;
  logic [STAT_W-1:0]  dec_status;

  assign in_ready = (state == ST_IDLE);
  assign last     = tok[ENTRIES];

  always_comb begin
    tok[0]        = '0;
    tok[0].active = start;
    tok[0].status = STATUS_OK;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    bctt_cell #(.INDEX(i)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .req  (req),
      .wr   (wr),
      .tin  (tok[i]),
      .tout (tok[i+1])
    );
  end

  // final decision when the token leaves the last cell
  always_comb begin
    dec_idx    = req.slot;
    dec_hit    = 1'b0;
    dec_fill   = 1'b0;
    dec_status = last.status;
    wr         = '0;
    wr.idx     = last.vidx;
    wr.stamp   = req_now;
    if (req.mode == MODE_GET) begin
      if (last.hit) begin
        dec_idx = last.hit_idx[SLOT_W-1:0];
        dec_hit = 1'b1;
      end else if (last.vfound) begin
        dec_idx    = last.vidx[SLOT_W-1:0];
        dec_fill   = 1'b1;
        dec_status = STATUS_OK;
        wr.en      = last.active;
      end else begin
        dec_idx    = '0;
        dec_status = STATUS_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start <= 1'b0;
      if (state == ST_HOLD && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            start <= 1'b1;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (last.active) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req.mode         <= mode;
      req.device       <= device;
      req.block_number <= block_number;
      req.slot         <= slot;
      req_now          <= now;
    end
    if (state == ST_SCAN && last.active) begin
      res_idx    <= dec_idx;
      res_hit    <= dec_hit;
      res_fill   <= dec_fill;
      res_status <= dec_status;
    end
    if (state == ST_HOLD && (!out_valid || out_ready)) begin
      entry_index <= res_idx;
      hit         <= res_hit;
      needs_fill  <= res_fill;
      status      <= res_status;
    end
  end

endmodule

`default_nettype wire
